// ===== rtl/core/iorb_pkg.sv =====
// Shared types and constants of the in-order release buffer.
`default_nettype none

package iorb_pkg;

   localparam int SEQ_W      = 31;
   localparam int HASH_W     = 64;
   localparam int STAMP_W    = 64;
   localparam int WINDOW_DEF = 32;

   // result status codes
   typedef enum logic [1:0] {
      ST_RELEASED = 2'd0,
      ST_BEYOND   = 2'd1,
      ST_LATE     = 2'd2
   } status_type;

   // control sequencer
   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOKUP,
      S_EMIT
   } state_type;

   // classification of an accepted request against the window
   typedef enum logic [1:0] {
      K_DUE,
      K_AHEAD,
      K_BEYOND,
      K_LATE
   } kind_type;

   // one pending-store entry
   typedef struct packed {
      logic               valid;
      logic               drop;
      logic [HASH_W-1:0]  hash;
      logic [STAMP_W-1:0] stamp;
   } slot_type;

endpackage

`default_nettype wire

// ===== rtl/core/iorb_req_if.sv =====
// Request channel of the in-order release buffer.
`default_nettype none

interface iorb_req_if
   import iorb_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [SEQ_W-1:0]   seq_in;
   logic               drop_in;
   logic [HASH_W-1:0]  hash_in;
   logic [STAMP_W-1:0] stamp_in;

   modport source (output valid, seq_in, drop_in, hash_in, stamp_in, input ready);
   modport sink   (input valid, seq_in, drop_in, hash_in, stamp_in, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/iorb_rsp_if.sv =====
// Result channel of the in-order release buffer.
`default_nettype none

interface iorb_rsp_if
   import iorb_pkg::*;
();
   logic               valid;
   logic               ready;
   status_type         status;
   logic [SEQ_W-1:0]   seq_out;
   logic               drop_out;
   logic [HASH_W-1:0]  hash_out;
   logic [STAMP_W-1:0] stamp_out;
   logic               last;

   modport source (output valid, status, seq_out, drop_out, hash_out, stamp_out, last,
                   input ready);
   modport sink   (input valid, status, seq_out, drop_out, hash_out, stamp_out, last,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/core/in_order_release_buffer.sv =====
// In-order release buffer: takes finished packet records that arrive out of order and
// hands them on strictly by sequence number. The block tracks next_due, the sequence
// number that must leave next, and holds up to WINDOW-1 records that are ahead of it in a
// single-port-read RAM indexed by sequence modulo WINDOW. A request carrying the due
// number is released at once, followed by every consecutive stored record; the final
// result of a burst carries last. A request ahead within the window is stored silently;
// one on an occupied slot, before next_due (serial order) or beyond the window is
// rejected with one status result. After reset the block sweeps every RAM slot to
// clear the valid marks and takes no request meanwhile. Each request is accepted, and
// then looked up in the RAM or released, before the next is taken; a release burst adds
// a step per stored record freed, since each freed slot is read ahead of its release
// through the RAM's registered read port. A stalled result channel holds the block.
`default_nettype none

module in_order_release_buffer
   import iorb_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   iorb_req_if.sink   req_chan,
   iorb_rsp_if.source rsp_chan
);

   localparam int AW  = $clog2(WINDOW);
   localparam int AW1 = AW + 1;
   localparam logic [AW1-1:0]   WinCnt  = AW1'(WINDOW);
   localparam logic [AW-1:0]    LastIdx = AW'(WINDOW - 1);
   localparam logic [SEQ_W-1:0] WinSeq  = SEQ_W'(WINDOW);

   // slot arithmetic modulo WINDOW (any window size, not only powers of two)
   function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
      if (s == LastIdx) begin
         return '0;
      end
      return s + AW'(1);
   endfunction

   function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] s,
                                              input logic [AW-1:0] dd);
      logic [AW1-1:0] sum;
      sum = {1'b0, s} + {1'b0, dd};
      if (sum >= WinCnt) begin
         sum = sum - WinCnt;
      end
      return sum[AW-1:0];
   endfunction

   // ---------------------------------------------------------------- state
   state_type          state_ff, state_in;
   logic [AW-1:0]      clr_ff, clr_in;          // clearing-pass pointer
   logic [SEQ_W-1:0]   next_due_ff, next_due_in;
   logic [AW-1:0]      head_ff, head_in;        // slot belonging to next_due

   // request held for the lookup / pending record of a release burst
   kind_type           kind_ff;
   logic [AW-1:0]      slot_ff;
   logic [SEQ_W-1:0]   seq_ff;
   logic               drop_ff;
   logic [HASH_W-1:0]  hash_ff;
   logic [STAMP_W-1:0] stamp_ff;

   // result register
   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [SEQ_W-1:0]   rsp_seq_ff;
   logic               rsp_drop_ff;
   logic [HASH_W-1:0]  rsp_hash_ff;
   logic [STAMP_W-1:0] rsp_stamp_ff;
   logic               rsp_last_ff;

   // ---------------------------------------------------------------- RAM
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   slot_type      wr_data;
   logic [AW-1:0] rd_addr;
   slot_type      rd_data;

   iorb_ram #(
      .WIDTH ($bits(slot_type)),
      .DEPTH (WINDOW)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---------------------------------------------------------------- classify
   logic [SEQ_W-1:0] seq_dist;
   logic [AW-1:0]    head_p1, head_p2;
   kind_type         req_kind;

   assign seq_dist = req_chan.seq_in - next_due_ff;   // serial distance, wraps mod 2^31
   assign head_p1  = slot_inc(head_ff);
   assign head_p2  = slot_inc(head_p1);

   always_comb begin
      if (seq_dist == '0) begin
         req_kind = K_DUE;
      end else if (seq_dist < WinSeq) begin
         req_kind = K_AHEAD;
      end else if (!seq_dist[SEQ_W-1]) begin
         req_kind = K_BEYOND;      // below half range: ahead but too far
      end else begin
         req_kind = K_LATE;        // before next_due in serial order
      end
   end

   // ---------------------------------------------------------------- control
   logic       req_ready;
   logic       capture;     // latch the request
   logic       pend_load;   // next stored record becomes the pending one
   logic       out_free;
   logic       rsp_load;
   status_type rsp_status_in;
   logic       rsp_last_in;
   logic       rsp_rel;     // result carries record payload
   logic [AW-1:0] slot_in;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign slot_in  = slot_add(head_ff, seq_dist[AW-1:0]);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      next_due_in   = next_due_ff;
      head_in       = head_ff;
      req_ready     = 1'b0;
      capture       = 1'b0;
      pend_load     = 1'b0;
      rsp_load      = 1'b0;
      rsp_status_in = ST_LATE;
      rsp_last_in   = 1'b1;
      rsp_rel       = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = slot_ff;
      wr_data       = '0;
      rd_addr       = slot_ff;

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = slot_inc(clr_ff);
            if (clr_ff == LastIdx) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            req_ready = 1'b1;
            // due request: look at the slot after it; otherwise at its own slot
            rd_addr   = (req_kind == K_DUE) ? head_p1 : slot_in;
            if (req_chan.valid) begin
               capture  = 1'b1;
               state_in = (req_kind == K_DUE) ? S_EMIT : S_LOOKUP;
            end
         end

         S_LOOKUP: begin
            case (kind_ff)
               K_AHEAD: begin
                  if (!rd_data.valid) begin
                     wr_en         = 1'b1;
                     wr_data.valid = 1'b1;
                     wr_data.drop  = drop_ff;
                     wr_data.hash  = hash_ff;
                     wr_data.stamp = stamp_ff;
                     state_in      = S_IDLE;
                  end else if (out_free) begin
                     rsp_load      = 1'b1;
                     rsp_status_in = ST_LATE;    // duplicate
                     state_in      = S_IDLE;
                  end
               end
               K_BEYOND: begin
                  if (out_free) begin
                     rsp_load      = 1'b1;
                     rsp_status_in = ST_BEYOND;
                     state_in      = S_IDLE;
                  end
               end
               default: begin
                  if (out_free) begin
                     rsp_load      = 1'b1;
                     rsp_status_in = ST_LATE;
                     state_in      = S_IDLE;
                  end
               end
            endcase
         end

         S_EMIT: begin
            // pending record sits at head; rd_data is the slot after it
            rd_addr = head_p1;
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = ST_RELEASED;
               rsp_rel       = 1'b1;
               rsp_last_in   = !rd_data.valid;
               next_due_in   = next_due_ff + SEQ_W'(1);
               head_in       = head_p1;
               if (rd_data.valid) begin
                  pend_load = 1'b1;
                  wr_en     = 1'b1;        // free the slot being drained
                  wr_addr   = head_p1;
                  rd_addr   = head_p2;     // look one slot further
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         next_due_ff  <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         next_due_ff <= next_due_in;
         head_ff     <= head_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         kind_ff  <= req_kind;
         slot_ff  <= slot_in;
         seq_ff   <= req_chan.seq_in;
         drop_ff  <= req_chan.drop_in;
         hash_ff  <= req_chan.hash_in;
         stamp_ff <= req_chan.stamp_in;
      end else if (pend_load) begin
         drop_ff  <= rd_data.drop;
         hash_ff  <= rd_data.hash;
         stamp_ff <= rd_data.stamp;
      end
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_seq_ff    <= rsp_rel ? next_due_ff : seq_ff;
         rsp_drop_ff   <= rsp_rel ? drop_ff     : 1'b0;
         rsp_hash_ff   <= rsp_rel ? hash_ff     : '0;
         rsp_stamp_ff  <= rsp_rel ? stamp_ff    : '0;
      end
   end

   // ---------------------------------------------------------------- ports
   assign req_chan.ready     = req_ready;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.seq_out   = rsp_seq_ff;
   assign rsp_chan.drop_out  = rsp_drop_ff;
   assign rsp_chan.hash_out  = rsp_hash_ff;
   assign rsp_chan.stamp_out = rsp_stamp_ff;
   assign rsp_chan.last      = rsp_last_ff;

   // ---------------------------------------------------------------- checks
   // each release moves next_due on by exactly one
   a_release_advances: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_status_in == ST_RELEASED)
      |=> next_due_ff == $past(next_due_ff) + SEQ_W'(1))
      else $error("next_due did not advance on release");

   // rejections and stores leave next_due alone
   a_reject_holds_due: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOKUP) |=> next_due_ff == $past(next_due_ff))
      else $error("next_due moved without a release");

   // draining never reads the slot it is freeing in the same cycle
   a_drain_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && wr_en) |-> wr_addr != rd_addr)
      else $error("read and write of one slot while draining");

endmodule

`default_nettype wire

// ===== rtl/core/iorb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module iorb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire
